>>> hw/rtl/ac2k_pkg.sv
`timescale 1ns / 1ps

package ac2k_pkg;

    // Width of one signed feature.
    localparam int FEATURE_WIDTH = 16;
    // Width of the signed accumulator and of the kernel value.
    localparam int ACC_WIDTH = 40;

    // One feature pair request.
    typedef struct packed {
        logic signed [FEATURE_WIDTH-1:0] x_feature;
        logic signed [FEATURE_WIDTH-1:0] y_feature;
        logic                            last;
    } in_t;

    // One kernel result.
    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] kernel_value;
        logic                        saturated;
    } out_t;

endpackage

>>> hw/rtl/additive_chi2_kernel_pair_core.sv
// A last pair passes through the square, divide and accumulate steps before its result is registered.
// A new pair is taken only once the previous one is through; a zero pair sum skips square and divide.
// The restoring divider retires one quotient bit per cycle.
// A last pair waits in its accumulate step while an earlier result is still held.
// Reset is synchronous and active low; it clears the accumulator, the clip flag and the result valid flag.
`timescale 1ns / 1ps

module additive_chi2_kernel_pair_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ac2k_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ac2k_pkg::out_t m_data
);

    localparam int FW = ac2k_pkg::FEATURE_WIDTH;
    localparam int AW = ac2k_pkg::ACC_WIDTH;
    localparam int QW = 2 * FW;
    localparam int RW = FW + 2;
    localparam int EW = ((QW > AW) ? QW : AW) + 1;
    localparam int CW = $clog2(QW);
    localparam logic [AW-1:0] ACC_BIAS = {1'b1, {(AW-1){1'b0}}};
    localparam logic [AW-1:0] ACC_MAX  = {AW{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_DIVIDE,
        ST_ACCUM
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   acc_reg, acc_next;
    logic            clip_reg, clip_next;
    logic            m_valid_reg, m_valid_next;
    ac2k_pkg::out_t  m_data_reg, m_data_next;
    logic [FW:0]     abs_s_reg, abs_s_next;
    logic [FW-1:0]   abs_d_reg, abs_d_next;
    logic            s_neg_reg, s_neg_next;
    logic            last_reg, last_next;
    logic [QW-1:0]   qn_reg, qn_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    logic signed [FW:0] sum_in, dif_in;
    logic [FW:0]        sum_mag, dif_mag;
    logic [QW-1:0]      square;
    logic [RW-1:0]      shifted;
    logic [RW:0]        trial;
    logic [EW-1:0]      acc_ext, q_ext, acc_plus, acc_minus;
    logic [AW-1:0]      acc_new;
    logic               clip_now;
    logic               out_blocked;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sum and difference of the incoming pair, and their magnitudes.
    always_comb begin
        sum_in  = {s_data.x_feature[FW-1], s_data.x_feature}
                + {s_data.y_feature[FW-1], s_data.y_feature};
        dif_in  = {s_data.x_feature[FW-1], s_data.x_feature}
                - {s_data.y_feature[FW-1], s_data.y_feature};
        sum_mag = sum_in[FW] ? (~sum_in + 1'b1) : sum_in;
        dif_mag = dif_in[FW] ? (~dif_in + 1'b1) : dif_in;
    end

    // Squared difference, formed once per pair.
    assign square = abs_d_reg * abs_d_reg;

    // One restoring division step: shift in a numerator bit and try the subtract.
    assign shifted = {rem_reg[RW-2:0], qn_reg[QW-1]};
    assign trial   = {1'b0, shifted} - {1'b0, 1'b0, abs_s_reg};

    // Saturating update of the biased accumulator by the quotient.
    always_comb begin
        acc_ext   = EW'(acc_reg);
        q_ext     = EW'(qn_reg);
        acc_plus  = acc_ext + q_ext;
        acc_minus = acc_ext - q_ext;
        if (s_neg_reg) begin
            clip_now = (acc_plus[EW-1:AW] != '0);
            acc_new  = clip_now ? ACC_MAX : acc_plus[AW-1:0];
        end else begin
            clip_now = acc_minus[EW-1];
            acc_new  = clip_now ? '0 : acc_minus[AW-1:0];
        end
    end

    assign out_blocked = m_valid_reg && !m_ready;

    // Sequencer: accept, square, divide, accumulate.
    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        clip_next    = clip_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        abs_s_next   = abs_s_reg;
        abs_d_next   = abs_d_reg;
        s_neg_next   = s_neg_reg;
        last_next    = last_reg;
        qn_next      = qn_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    abs_s_next = sum_mag;
                    abs_d_next = dif_mag[FW-1:0];
                    s_neg_next = sum_in[FW];
                    last_next  = s_data.last;
                    // A zero sum contributes nothing, so the divider is skipped.
                    if (sum_in == '0) begin
                        qn_next    = '0;
                        state_next = ST_ACCUM;
                    end else begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE: begin
                qn_next    = square;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (!trial[RW]) begin
                    rem_next = trial[RW-1:0];
                    qn_next  = {qn_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next = shifted;
                    qn_next  = {qn_reg[QW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1)) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                if (!last_reg) begin
                    acc_next   = acc_new;
                    clip_next  = clip_reg | clip_now;
                    state_next = ST_IDLE;
                end else if (!out_blocked) begin
                    m_data_next.kernel_value = signed'(acc_new ^ ACC_BIAS);
                    m_data_next.saturated    = clip_reg | clip_now;
                    m_valid_next = 1'b1;
                    acc_next     = ACC_BIAS;
                    clip_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, accumulator and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= ACC_BIAS;
            clip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            clip_reg    <= clip_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        abs_s_reg  <= abs_s_next;
        abs_d_reg  <= abs_d_next;
        s_neg_reg  <= s_neg_next;
        last_reg   <= last_next;
        qn_reg     <= qn_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
    end

`ifndef SYNTHESIS
    // A request moves the sequencer out of idle at once.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("block still ready after accepting a request");

    // The partial remainder stays below the divisor.
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE) |-> (rem_reg < {1'b0, abs_s_reg}))
        else $error("divider remainder reached the divisor");

    // The step counter advances by one per division step.
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE && cnt_reg != CW'(QW - 1))
        |=> (state_reg == ST_DIVIDE && cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("divider step counter skipped");

    // A new result leaves the accumulator and clip flag cleared.
    a_clear_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (acc_reg == ACC_BIAS && !clip_reg))
        else $error("accumulator not cleared after a result");

    // A result appears only from the accumulate step of a last pair.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_ACCUM && last_reg))
        else $error("result produced outside a last pair");
`endif

endmodule

>>> test/additive_chi2_kernel_pair_core_tb.sv
`timescale 1ns / 1ps

module additive_chi2_kernel_pair_core_tb;

    localparam int FW = ac2k_pkg::FEATURE_WIDTH;
    localparam int AW = ac2k_pkg::ACC_WIDTH;
    localparam longint KERNEL_MAX = (longint'(1) << (AW - 1)) - 1;
    localparam longint KERNEL_MIN = -KERNEL_MAX - 1;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 530;
    localparam int QUIET_FROM = 490;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 80;
    localparam longint TIMEOUT_NS = 5_000_000;

    // Keeps a running copy of the chi-squared sum and the expected kernel values.
    class kernel_predictor;
        ac2k_pkg::out_t expected_kernels[$];
        longint chi2_sum;
        bit     clip_seen;
        int     error_count;

        function new();
            chi2_sum = 0;
            clip_seen = 1'b0;
            error_count = 0;
        endfunction

        function int pending();
            return expected_kernels.size();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            error_count++;
        endtask

        // Fold one accepted pair into the sum; a last pair closes the vector pair.
        function void note_request(ac2k_pkg::in_t req);
            longint x_val;
            longint y_val;
            longint pair_sum;
            longint pair_diff;
            longint quotient;
            ac2k_pkg::out_t kernel;
            x_val = longint'(req.x_feature);
            y_val = longint'(req.y_feature);
            pair_sum = x_val + y_val;
            pair_diff = x_val - y_val;
            if (pair_sum != 0) begin
                // Magnitudes are divided, so the quotient truncates toward zero.
                quotient = (pair_diff * pair_diff) / (pair_sum < 0 ? -pair_sum : pair_sum);
                if (pair_sum > 0) begin
                    chi2_sum = chi2_sum - quotient;
                end else begin
                    chi2_sum = chi2_sum + quotient;
                end
                if (chi2_sum > KERNEL_MAX) begin
                    chi2_sum = KERNEL_MAX;
                    clip_seen = 1'b1;
                end else if (chi2_sum < KERNEL_MIN) begin
                    chi2_sum = KERNEL_MIN;
                    clip_seen = 1'b1;
                end
            end
            if (req.last) begin
                kernel.kernel_value = chi2_sum[AW-1:0];
                kernel.saturated = clip_seen;
                expected_kernels.push_back(kernel);
                chi2_sum = 0;
                clip_seen = 1'b0;
            end
        endfunction

        // Compare one delivered kernel with the oldest one expected.
        task check_result(ac2k_pkg::out_t got);
            ac2k_pkg::out_t want;
            if (expected_kernels.size() == 0) begin
                report($sformatf("kernel %0d arrived with no request pending",
                                 got.kernel_value));
                return;
            end
            want = expected_kernels.pop_front();
            if (got.kernel_value !== want.kernel_value) begin
                report($sformatf("kernel_value %0d, expected %0d",
                                 got.kernel_value, want.kernel_value));
            end
            if (got.saturated !== want.saturated) begin
                report($sformatf("saturated %b, expected %b (kernel %0d)",
                                 got.saturated, want.saturated, want.kernel_value));
            end
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ac2k_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ac2k_pkg::out_t m_data;

    kernel_predictor predictor = new();
    int  items_sent = 0;
    int  vector_count = 0;
    bit  quiet_tail = 1'b0;
    bit  hold_armed = 1'b0;

    additive_chi2_kernel_pair_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // Watch both channels; results are checked before the request of the same edge is noted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                predictor.check_result(m_data);
            end
            if (s_valid && s_ready) begin
                predictor.note_request(s_data);
            end
        end
    end

    // Result side: short random stalls, one long hold-off, and none in the tail.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            if (hold_armed && !hold_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // Offer one request and hold it until it is taken; sometimes pause afterwards.
    task automatic send_request(input ac2k_pkg::in_t req);
        s_data <= req;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (items_sent >= QUIET_FROM) quiet_tail = 1'b1;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic offer_pair(input logic signed [FW-1:0] x_val,
                              input logic signed [FW-1:0] y_val,
                              input logic last_pair);
        ac2k_pkg::in_t req;
        req.x_feature = x_val;
        req.y_feature = y_val;
        req.last = last_pair;
        send_request(req);
    endtask

    function automatic logic signed [FW-1:0] extreme_feature();
        logic signed [FW-1:0] val;
        case ($urandom_range(0, 4))
            0: val = {1'b1, {(FW - 1){1'b0}}};
            1: val = {1'b0, {(FW - 1){1'b1}}};
            2: val = '1;
            3: val = FW'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

    // One vector pair of random content, with a mix of special shapes per pair.
    task automatic send_random_vector(input int pair_count);
        logic signed [FW-1:0] x_val;
        logic signed [FW-1:0] y_val;
        for (int i = 0; i < pair_count; i++) begin
            x_val = FW'($urandom);
            y_val = FW'($urandom);
            case ($urandom_range(0, 9))
                5: y_val = -x_val;
                6: begin
                    x_val = FW'(int'($urandom_range(0, 31)) - 16);
                    y_val = FW'(int'($urandom_range(0, 31)) - 16);
                end
                7: begin
                    x_val = extreme_feature();
                    y_val = extreme_feature();
                end
                8: y_val = FW'(-x_val + int'($urandom_range(0, 6)) - 3);
                9: y_val = x_val;
                default: ;
            endcase
            offer_pair(x_val, y_val, i == pair_count - 1);
        end
    endtask

    // A long run of near-maximal terms of one sign that drives the sum into its bound.
    task automatic send_clipping_vector(input bit upward);
        logic signed [FW-1:0] x_val;
        logic signed [FW-1:0] y_val;
        int pair_count;
        pair_count = int'($urandom_range(150, 170));
        for (int i = 0; i < pair_count; i++) begin
            x_val = FW'($urandom_range(32500, 32767));
            // A sum of -1 adds the squared difference, a sum of +1 subtracts it.
            y_val = upward ? FW'(-x_val - 1) : FW'(1 - x_val);
            offer_pair(x_val, y_val, i == pair_count - 1);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single pairs at the field extremes, including zero sums and zero differences.
        offer_pair(16'sh7fff, 16'sh8000, 1'b1);
        offer_pair(16'sh8000, 16'sh7fff, 1'b1);
        offer_pair(16'sd100, -16'sd100, 1'b1);
        offer_pair(16'sh8000, 16'sh8000, 1'b1);
        offer_pair(16'sh7fff, 16'sh7fff, 1'b1);
        offer_pair(16'sd0, 16'sd0, 1'b1);
        // Truncated quotients with both signs of the sum.
        offer_pair(16'sd3, 16'sd1, 1'b0);
        offer_pair(16'sd5, 16'sd2, 1'b0);
        offer_pair(-16'sd5, -16'sd2, 1'b1);
        offer_pair(16'sh7fff, -16'sd32766, 1'b0);
        offer_pair(16'sd1, -16'sd1, 1'b0);
        offer_pair(-16'sd1, 16'sd0, 1'b1);
        offer_pair(16'sh8000, 16'sd0, 1'b0);
        offer_pair(16'sd0, 16'sh8000, 1'b0);
        offer_pair(16'sh7fff, 16'sd0, 1'b0);
        offer_pair(16'sd0, 16'sh7fff, 1'b1);
        offer_pair(16'sd1, 16'sd1, 1'b0);
        offer_pair(16'sd1, 16'sd2, 1'b0);
        offer_pair(-16'sd7, 16'sd3, 1'b1);
        // The last pair has a zero sum, so the total comes from the earlier pair only.
        offer_pair(16'sh8000, 16'sh7fff, 1'b0);
        offer_pair(-16'sd32767, 16'sh7fff, 1'b1);

        // Random vector pairs, two of them long enough to clip, one in each direction.
        while (items_sent < 21 + RANDOM_ITEMS) begin
            vector_count++;
            if (vector_count == 10) hold_armed = 1'b1;
            if (vector_count == 2) begin
                send_clipping_vector(1'b1);
            end else if (vector_count == 5) begin
                send_clipping_vector(1'b0);
            end else begin
                send_random_vector(int'($urandom_range(1, 8)));
            end
        end

        s_valid <= 1'b0;
        while (predictor.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (predictor.error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ac2k_pkg.sv
hw/rtl/additive_chi2_kernel_pair_core.sv
test/additive_chi2_kernel_pair_core_tb.sv
